>>> rtl/core/wbwc_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and a saturating add for the word break way counter
package wbwc_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned WaysW = 63;
  localparam int unsigned TotW  = 32;

  localparam logic [WaysW-1:0] WaysMax = {WaysW{1'b1}};
  localparam logic [TotW-1:0]  TotMax  = {TotW{1'b1}};

  typedef enum logic [1:0] {
    REQ_PAT   = 2'd0,
    REQ_TEXT  = 2'd1,
    REQ_CLEAR = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_SCAN,
    ST_DONE
  } state_e;

  // saturating add of two counts
  function automatic logic [WaysW-1:0] sat_add(input logic [WaysW-1:0] a,
                                               input logic [WaysW-1:0] b);
    logic [WaysW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[WaysW] ? WaysMax : s[WaysW-1:0];
  endfunction

endpackage

>>> rtl/core/wbwc_cell.sv
`timescale 1ns / 1ps
// one window cell: holds a text character and the count one step further back
module wbwc_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       shift_i,
  input  logic [wbwc_pkg::SymW-1:0]  sym_i,
  input  logic [wbwc_pkg::WaysW-1:0] ways_i,
  output logic [wbwc_pkg::SymW-1:0]  sym_o,
  output logic [wbwc_pkg::WaysW-1:0] ways_o
);
  import wbwc_pkg::*;

  logic [SymW-1:0]  sym_q;
  logic [WaysW-1:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q  <= '0;
      ways_q <= '0;
    end else if (clear_i) begin
      sym_q  <= '0;
      ways_q <= '0;
    end else if (shift_i) begin
      sym_q  <= sym_i;
      ways_q <= ways_i;
    end
  end

  assign sym_o  = sym_q;
  assign ways_o = ways_q;

endmodule

>>> rtl/core/word_break_way_counter_core.sv
`timescale 1ns / 1ps
// Word break way counter: patterns are loaded one character per request
// (req_type 0) and text one character per request (req_type 1); a clear
// request (req_type 2) empties the dictionary and totals. A text character
// shifts into a chain of MAX_PAT_LEN window cells, then a fetch state primes
// the registered pattern memory read and the stored patterns are checked one
// per cycle against the window; with an empty dictionary the fetch and scan
// are skipped. A result appears on a text request that carries last and waits
// in an output register; while that register is still full, the next string
// end holds the block until the result is taken.
module word_break_way_counter_core #(
  parameter int unsigned NUM_PATTERNS = 64,
  parameter int unsigned MAX_PAT_LEN  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [1:0]                 req_type_i,
  input  logic [wbwc_pkg::SymW-1:0]  symbol_i,
  input  logic                       last_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [wbwc_pkg::WaysW-1:0] ways_o,
  output logic                       possible_o,
  output logic [wbwc_pkg::TotW-1:0]  total_possible_o,
  output logic [wbwc_pkg::WaysW-1:0] total_ways_o,
  output logic                       dict_error_o
);
  import wbwc_pkg::*;

  localparam int unsigned PW = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
  localparam int unsigned CW = $clog2(NUM_PATTERNS + 1);
  localparam int unsigned LW = $clog2(MAX_PAT_LEN + 1);
  localparam int unsigned TW = $clog2(MAX_PAT_LEN + 2);
  localparam int unsigned RW = MAX_PAT_LEN * SymW;

  state_e state_q, state_d;

  logic [CW-1:0]    pcount_q;
  logic [LW-1:0]    lpos_q;
  logic             lbad_q;
  logic [RW-1:0]    lrow_q;
  logic [TW-1:0]    tpos_q;
  logic [TotW-1:0]  sum_pos_q;
  logic [WaysW-1:0] sum_ways_q;
  logic             err_q;
  logic             last_q;
  logic [PW-1:0]    pidx_q;
  logic [WaysW-1:0] acc_q;
  logic             ovalid_q;
  logic [WaysW-1:0] ways_q;
  logic             possible_q;
  logic [TotW-1:0]  tot_pos_q;
  logic [WaysW-1:0] tot_ways_q;
  logic             derr_q;

  // one row per pattern, characters reversed so index j is j back from the end
  logic [RW-1:0]    pat_mem [NUM_PATTERNS];
  logic [LW-1:0]    len_mem [NUM_PATTERNS];
  logic [RW-1:0]    rd_row_q;
  logic [LW-1:0]    rd_len_q;

  logic acc_in, do_pat, do_text, do_clear, shift;
  assign acc_in   = in_valid_i && in_ready_o;
  assign do_pat   = acc_in && (req_type_i == REQ_PAT);
  assign do_text  = acc_in && (req_type_i == REQ_TEXT);
  assign do_clear = acc_in && (req_type_i == REQ_CLEAR);
  assign shift    = do_text;

  logic [SymW-1:0]  csym  [MAX_PAT_LEN];
  logic [WaysW-1:0] cways [MAX_PAT_LEN];
  logic text_clear;

  for (genvar k = 0; k < MAX_PAT_LEN; k++) begin : g_cell
    if (k == 0) begin : g_head
      wbwc_cell u_cell (
        .clk_i, .rst_ni, .clear_i(text_clear), .shift_i(shift),
        .sym_i(symbol_i), .ways_i(acc_q), .sym_o(csym[k]), .ways_o(cways[k])
      );
    end else begin : g_body
      wbwc_cell u_cell (
        .clk_i, .rst_ni, .clear_i(text_clear), .shift_i(shift),
        .sym_i(csym[k-1]), .ways_i(cways[k-1]), .sym_o(csym[k]), .ways_o(cways[k])
      );
    end
  end

  // match the fetched pattern against the window
  logic match;
  logic [WaysW-1:0] addend;
  always_comb begin
    match = (rd_len_q != '0) && (TW'(rd_len_q) <= tpos_q);
    for (int j = 0; j < MAX_PAT_LEN; j++) begin
      if (LW'(j) < rd_len_q && csym[j] != rd_row_q[j*SymW +: SymW]) match = 1'b0;
    end
    addend = '0;
    if (TW'(rd_len_q) == tpos_q) begin
      addend = WaysW'(1);
    end else begin
      for (int j = 0; j < MAX_PAT_LEN; j++) begin
        if (LW'(j + 1) == rd_len_q) addend = cways[j];
      end
    end
  end

  logic scan_end;
  assign scan_end = (CW'(pidx_q) + CW'(1) >= pcount_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (do_text) state_d = (pcount_q == '0) ? ST_DONE : ST_FETCH;
      ST_FETCH: state_d = ST_SCAN;
      ST_SCAN:  if (scan_end) state_d = ST_DONE; else state_d = ST_SCAN;
      ST_DONE:  if (!last_q || !ovalid_q) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
  end

  logic finish;
  assign finish     = (state_q == ST_DONE) && (!last_q || !ovalid_q);
  assign text_clear = do_clear || (finish && last_q);

  logic [WaysW-1:0] f;
  assign f = acc_q;

  logic [TotW-1:0]  sum_pos_d;
  logic [WaysW-1:0] sum_ways_d;
  assign sum_pos_d  = (f != '0 && sum_pos_q != TotMax) ? sum_pos_q + TotW'(1) : sum_pos_q;
  assign sum_ways_d = sat_add(sum_ways_q, f);

  always_ff @(posedge clk_i) begin
    if (state_q == ST_FETCH || (state_q == ST_SCAN && !scan_end)) begin
      rd_row_q <= pat_mem[(state_q == ST_FETCH) ? pidx_q : pidx_q + PW'(1)];
      rd_len_q <= len_mem[(state_q == ST_FETCH) ? pidx_q : pidx_q + PW'(1)];
    end
    if (do_pat && last_i && !lbad_q && pcount_q < CW'(NUM_PATTERNS)
        && lpos_q < LW'(MAX_PAT_LEN)) begin
      pat_mem[pcount_q[PW-1:0]] <= (lrow_q << SymW) | RW'(symbol_i);
      len_mem[pcount_q[PW-1:0]] <= lpos_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pcount_q   <= '0;
      lpos_q     <= '0;
      lbad_q     <= 1'b0;
      tpos_q     <= '0;
      sum_pos_q  <= '0;
      sum_ways_q <= '0;
      err_q      <= 1'b0;
      last_q     <= 1'b0;
      pidx_q     <= '0;
      acc_q      <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      if (do_clear) begin
        pcount_q <= '0; lpos_q <= '0; lbad_q <= 1'b0; tpos_q <= '0;
        sum_pos_q <= '0; sum_ways_q <= '0; err_q <= 1'b0;
      end
      if (do_pat) begin
        if (pcount_q >= CW'(NUM_PATTERNS) || lpos_q >= LW'(MAX_PAT_LEN)) begin
          err_q <= 1'b1;
          lbad_q <= !last_i;
          if (last_i) lpos_q <= '0;
        end else if (last_i) begin
          if (!lbad_q) pcount_q <= pcount_q + CW'(1);
          lpos_q <= '0;
          lbad_q <= 1'b0;
        end else begin
          lpos_q <= lpos_q + LW'(1);
        end
      end
      if (do_text) begin
        last_q <= last_i;
        pidx_q <= '0;
        acc_q  <= '0;
        // runs one past the window so no pattern counts as a string start there
        if (tpos_q <= TW'(MAX_PAT_LEN)) tpos_q <= tpos_q + TW'(1);
      end
      if (state_q == ST_SCAN) begin
        if (match) acc_q <= sat_add(acc_q, addend);
        pidx_q <= pidx_q + PW'(1);
      end
      if (finish && last_q) begin
        tpos_q <= '0;
        ovalid_q <= 1'b1;
        sum_pos_q <= sum_pos_d;
        sum_ways_q <= sum_ways_d;
      end
    end
  end

  // pattern row assembly, newest character at the bottom, and the result registers
  always_ff @(posedge clk_i) begin
    if (do_pat) lrow_q <= (lpos_q == '0) ? RW'(symbol_i) : ((lrow_q << SymW) | RW'(symbol_i));
    if (finish && last_q) begin
      ways_q     <= f;
      possible_q <= (f != '0);
      tot_pos_q  <= sum_pos_d;
      tot_ways_q <= sum_ways_d;
      derr_q     <= err_q;
    end
  end

  assign out_valid_o      = ovalid_q;
  assign ways_o           = ways_q;
  assign possible_o       = possible_q;
  assign total_possible_o = tot_pos_q;
  assign total_ways_o     = tot_ways_q;
  assign dict_error_o     = derr_q;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == ST_IDLE) else $error("ready outside idle");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pcount_q <= CW'(NUM_PATTERNS)) else $error("pattern count overflow");
  a_tpos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tpos_q <= TW'(MAX_PAT_LEN + 1)) else $error("text position overflow");
  a_possible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> possible_o == (ways_o != '0)) else $error("possible mismatch");
`endif

endmodule
